@@ hdl/char_histogram_word_count_unit_macros.svh @@
// ----------------------------------------------------------------------------
// char histogram word count unit: assertion macros
// concurrent check helpers for the one block that uses them to assert
// ----------------------------------------------------------------------------
`ifndef CHAR_HISTOGRAM_WORD_COUNT_UNIT_MACROS_SVH
`define CHAR_HISTOGRAM_WORD_COUNT_UNIT_MACROS_SVH

// same-cycle implication
`define CHWC_ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CHWC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/chwc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chwc_pkg
// types and constants of the character histogram and word count unit
// ----------------------------------------------------------------------------
package chwc_pkg;

    localparam int NUM_BINS      = 95;
    localparam int BIN_WIDTH     = 7;
    localparam int OUT_WIDTH     = 32;
    localparam int FREQ_WIDTH    = 17;
    localparam int FREQ_LSB      = OUT_WIDTH;
    localparam int DIV_STEPS     = 17;
    localparam int STEP_WIDTH    = $clog2(DIV_STEPS);
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_WIDTH    = $clog2(QUEUE_DEPTH);
    localparam int S_TDATA_WIDTH = 24;
    localparam int M_TDATA_WIDTH = 120;
    localparam int M_USED_WIDTH  = 3 * OUT_WIDTH + FREQ_WIDTH;
    localparam int PADDR_WIDTH   = 3;
    localparam int PDATA_WIDTH   = 32;

    localparam logic [FREQ_WIDTH-1:0] Q_ONE = 17'h10000;

    // operation codes
    localparam logic [1:0] OP_COUNT = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // register addresses (word select bit of paddr)
    localparam logic REG_FOLD_CASE = 1'b0;

    // character classes
    localparam logic [7:0] FIRST_PRINTABLE = 8'd32;
    localparam logic [7:0] LAST_PRINTABLE  = 8'd126;
    localparam logic [7:0] UPPER_A         = 8'd65;
    localparam logic [7:0] UPPER_Z         = 8'd90;
    localparam logic [7:0] FOLD_OFFSET     = 8'd32;
    localparam logic [7:0] BLANK_FIRST     = 8'd9;
    localparam logic [7:0] BLANK_LAST      = 8'd13;
    localparam logic [7:0] SPACE           = 8'd32;

    typedef struct packed {
        logic [1:0]           op;
        logic                 blank;
        logic                 binned;
        logic [BIN_WIDTH-1:0] bin;
    } chwc_item_t;

    typedef struct packed {
        logic div_busy;
        logic div_last;
        logic total_zero;
    } chwc_status_t;

endpackage
`default_nettype wire

@@ hdl/char_histogram_word_count_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// char_histogram_word_count_unit
// byte histogram over the printable range with byte total and word count
// ----------------------------------------------------------------------------
// Each request on the input stream (count byte, read bin, clear) gives exactly
// one result. Requests enter a four-entry queue at one per cycle unless it is
// full; the back end then runs them one at a time. A count or clear goes through
// bin store read, write back and result register; a read of a bin with a nonzero
// total also uses the bit-serial frequency divider. Per-bin valid flags leave the
// bins empty right after reset, so there is no clearing pass. The user must write
// fold_case over the register port while the unit is idle; nothing enforces it.
// ----------------------------------------------------------------------------
`include "char_histogram_word_count_unit_macros.svh"

module char_histogram_word_count_unit
    import chwc_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    // opcode [1:0], data_byte [9:2], bin_index [16:10]
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    input  wire logic [S_TDATA_WIDTH-1:0] s_tdata,
    // bin_count [31:0], bin_frequency [48:32], total_bytes [80:49],
    // word_count [112:81]
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    output logic [M_TDATA_WIDTH-1:0]      m_tdata,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [PADDR_WIDTH-1:0]   paddr,
    input  wire logic [PDATA_WIDTH-1:0]   pwdata,
    output logic [PDATA_WIDTH-1:0]        prdata,
    output logic                          pready
);

    logic         fold_case_reg;
    logic         fold_case_next;
    logic         q_full;
    logic         q_empty;
    logic         q_push;
    logic         q_pop;
    chwc_item_t   push_item;
    chwc_item_t   head_item;
    chwc_status_t back_status;

    // register port
    assign pready = 1'b1;

    always_comb begin
        fold_case_next = fold_case_reg;
        if (psel && penable && pwrite && pready && (paddr[2] == REG_FOLD_CASE)) begin
            fold_case_next = pwdata[0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_FOLD_CASE) begin
            prdata = {{(PDATA_WIDTH-1){1'b0}}, fold_case_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fold_case_reg <= 1'b0;
        end else begin
            fold_case_reg <= fold_case_next;
        end
    end

    chwc_front u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .fold_case (fold_case_reg),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (push_item)
    );

    chwc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .head_item (head_item),
        .full      (q_full),
        .empty     (q_empty)
    );

    chwc_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_item   (head_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .status   (back_status)
    );

    `CHWC_ASSERT_IMPLIES(a_div_total_nonzero, aclk, aresetn, back_status.div_busy, !back_status.total_zero, "divider running with zero total")
    `CHWC_ASSERT_NEXT(a_div_full_length, aclk, aresetn, back_status.div_busy && !back_status.div_last, back_status.div_busy, "divider left before its last step")
    `CHWC_ASSERT_IMPLIES(a_freq_in_range, aclk, aresetn, m_tvalid, m_tdata[FREQ_LSB +: FREQ_WIDTH] <= Q_ONE, "frequency above one")

endmodule
`default_nettype wire

@@ hdl/chwc_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chwc_front
// takes requests off the input stream and classifies them for the back end
// ----------------------------------------------------------------------------
module chwc_front
    import chwc_pkg::*;
(
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    input  wire logic [S_TDATA_WIDTH-1:0] s_tdata,
    input  wire logic                     fold_case,
    input  wire logic                     q_full,
    output logic                          q_push,
    output chwc_item_t                    q_item
);

    logic [1:0]           op;
    logic [7:0]           data_byte;
    logic [BIN_WIDTH-1:0] bin_index;
    logic [7:0]           folded;
    logic [7:0]           offset;

    assign op        = s_tdata[1:0];
    assign data_byte = s_tdata[9:2];
    assign bin_index = s_tdata[16:10];

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb begin
        folded = data_byte;
        if (fold_case && (data_byte inside {[UPPER_A:UPPER_Z]})) begin
            folded = data_byte + FOLD_OFFSET;
        end
        offset = folded - FIRST_PRINTABLE;

        q_item.op     = op;
        q_item.blank  = (data_byte inside {[BLANK_FIRST:BLANK_LAST]}) || (data_byte == SPACE);
        q_item.binned = 1'b0;
        q_item.bin    = bin_index;
        case (op)
            OP_COUNT: begin
                q_item.binned = data_byte inside {[FIRST_PRINTABLE:LAST_PRINTABLE]};
                q_item.bin    = offset[BIN_WIDTH-1:0];
            end
            OP_READ: begin
                q_item.binned = bin_index < BIN_WIDTH'(NUM_BINS);
            end
            default: begin
                q_item.binned = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ hdl/chwc_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chwc_queue
// short request queue between the front and back ends
// ----------------------------------------------------------------------------
module chwc_queue
    import chwc_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       push,
    input  wire chwc_item_t push_item,
    input  wire logic       pop,
    output chwc_item_t      head_item,
    output logic            full,
    output logic            empty
);

    chwc_item_t            entry_reg [QUEUE_DEPTH];
    logic [QPTR_WIDTH-1:0] wr_ptr_reg;
    logic [QPTR_WIDTH-1:0] wr_ptr_next;
    logic [QPTR_WIDTH-1:0] rd_ptr_reg;
    logic [QPTR_WIDTH-1:0] rd_ptr_next;
    logic [QPTR_WIDTH:0]   level_reg;
    logic [QPTR_WIDTH:0]   level_next;
    logic                  do_push;
    logic                  do_pop;

    assign full      = level_reg == (QPTR_WIDTH + 1)'(QUEUE_DEPTH);
    assign empty     = level_reg == '0;
    assign head_item = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (do_push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            level_next = level_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule
`default_nettype wire

@@ hdl/chwc_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chwc_back
// bin memory, byte and word counters, frequency divider and result register
// ----------------------------------------------------------------------------
module chwc_back
    import chwc_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      q_empty,
    input  wire chwc_item_t                q_item,
    output logic                           q_pop,
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic [M_TDATA_WIDTH-1:0]       m_tdata,
    output chwc_status_t                   status
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MEM  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    logic [1:0]                state_reg;
    logic [1:0]                state_next;
    chwc_item_t                item_reg;
    chwc_item_t                item_next;
    logic [COUNT_WIDTH-1:0]    total_reg;
    logic [COUNT_WIDTH-1:0]    total_next;
    logic [COUNT_WIDTH-1:0]    words_reg;
    logic [COUNT_WIDTH-1:0]    words_next;
    logic                      inside_reg;
    logic                      inside_next;
    logic [NUM_BINS-1:0]       valid_reg;
    logic [NUM_BINS-1:0]       valid_next;
    logic [COUNT_WIDTH-1:0]    count_reg;
    logic [COUNT_WIDTH-1:0]    count_next;
    logic [FREQ_WIDTH-1:0]     freq_reg;
    logic [FREQ_WIDTH-1:0]     freq_next;
    logic [COUNT_WIDTH:0]      rem_reg;
    logic [COUNT_WIDTH:0]      rem_next;
    logic [FREQ_WIDTH-1:0]     quo_reg;
    logic [FREQ_WIDTH-1:0]     quo_next;
    logic [STEP_WIDTH-1:0]     step_reg;
    logic [STEP_WIDTH-1:0]     step_next;
    logic                      m_valid_reg;
    logic                      m_valid_next;
    logic [M_TDATA_WIDTH-1:0]  m_data_reg;
    logic [M_TDATA_WIDTH-1:0]  m_data_next;

    logic [COUNT_WIDTH-1:0]    mem [NUM_BINS];
    logic [COUNT_WIDTH-1:0]    rd_data_reg;
    logic                      mem_we;
    logic [COUNT_WIDTH-1:0]    mem_wdata;
    logic [COUNT_WIDTH-1:0]    bin_val;
    logic [COUNT_WIDTH:0]      rem_diff;
    logic [COUNT_WIDTH-1:0]    rem_kept;
    logic                      rem_ge;
    logic [COUNT_WIDTH-1:0]    words_live;
    logic [OUT_WIDTH-1:0]      count_out;
    logic [OUT_WIDTH-1:0]      total_out;
    logic [OUT_WIDTH-1:0]      words_out;
    logic                      out_free;

    assign words_live = (inside_reg && (words_reg != CNT_MAX)) ? words_reg + 1'b1 : words_reg;

    if (COUNT_WIDTH >= OUT_WIDTH) begin : g_out_wide
        assign count_out = count_reg[OUT_WIDTH-1:0];
        assign total_out = total_reg[OUT_WIDTH-1:0];
        assign words_out = words_live[OUT_WIDTH-1:0];
    end else begin : g_out_narrow
        assign count_out = {{(OUT_WIDTH-COUNT_WIDTH){1'b0}}, count_reg};
        assign total_out = {{(OUT_WIDTH-COUNT_WIDTH){1'b0}}, total_reg};
        assign words_out = {{(OUT_WIDTH-COUNT_WIDTH){1'b0}}, words_live};
    end

    // one restoring division step
    assign rem_diff = rem_reg - {1'b0, total_reg};
    assign rem_ge   = !rem_diff[COUNT_WIDTH];
    assign rem_kept = rem_ge ? rem_diff[COUNT_WIDTH-1:0] : rem_reg[COUNT_WIDTH-1:0];

    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        state_next   = state_reg;
        item_next    = item_reg;
        total_next   = total_reg;
        words_next   = words_reg;
        inside_next  = inside_reg;
        valid_next   = valid_reg;
        count_next   = count_reg;
        freq_next    = freq_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        step_next    = step_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        q_pop        = 1'b0;
        mem_we       = 1'b0;
        bin_val      = '0;
        mem_wdata    = '0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (!q_empty) begin
                    q_pop      = 1'b1;
                    item_next  = q_item;
                    count_next = '0;
                    freq_next  = '0;
                    state_next = S_MEM;
                    case (q_item.op)
                        OP_COUNT: begin
                            if (total_reg != CNT_MAX) begin
                                total_next = total_reg + 1'b1;
                            end
                            if (q_item.blank) begin
                                if (inside_reg && (words_reg != CNT_MAX)) begin
                                    words_next = words_reg + 1'b1;
                                end
                                inside_next = 1'b0;
                            end else begin
                                inside_next = 1'b1;
                            end
                        end
                        OP_CLEAR: begin
                            total_next  = '0;
                            words_next  = '0;
                            inside_next = 1'b0;
                            valid_next  = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_MEM: begin
                state_next = S_OUT;
                if (item_reg.binned) begin
                    bin_val   = valid_reg[item_reg.bin] ? rd_data_reg : '0;
                    mem_wdata = (bin_val == CNT_MAX) ? bin_val : bin_val + 1'b1;
                    if (item_reg.op == OP_COUNT) begin
                        mem_we                   = 1'b1;
                        valid_next[item_reg.bin] = 1'b1;
                    end else if (item_reg.op == OP_READ) begin
                        count_next = bin_val;
                        if (total_reg != '0) begin
                            rem_next   = {1'b0, bin_val};
                            quo_next   = '0;
                            step_next  = '0;
                            state_next = S_DIV;
                        end
                    end
                end
            end
            S_DIV: begin
                rem_next  = {rem_kept, 1'b0};
                quo_next  = {quo_reg[FREQ_WIDTH-2:0], rem_ge};
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_WIDTH'(DIV_STEPS - 1)) begin
                    freq_next  = (quo_next > Q_ONE) ? Q_ONE : quo_next;
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {{(M_TDATA_WIDTH-M_USED_WIDTH){1'b0}},
                                    words_out, total_out, freq_reg, count_out};
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            total_reg   <= '0;
            words_reg   <= '0;
            inside_reg  <= 1'b0;
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            total_reg   <= total_next;
            words_reg   <= words_next;
            inside_reg  <= inside_next;
            valid_reg   <= valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg   <= item_next;
        count_reg  <= count_next;
        freq_reg   <= freq_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        step_reg   <= step_next;
        m_data_reg <= m_data_next;
    end

    // bin store: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[item_reg.bin] <= mem_wdata;
        end
        rd_data_reg <= mem[q_item.bin];
    end

    assign m_tvalid          = m_valid_reg;
    assign m_tdata           = m_data_reg;
    assign status.div_busy   = state_reg == S_DIV;
    assign status.div_last   = step_reg == STEP_WIDTH'(DIV_STEPS - 1);
    assign status.total_zero = total_reg == '0;

endmodule
`default_nettype wire
